/* hw/rtl/coin_pulse_width_counter_unit_assert.svh */
// Assertion macros for the coin pulse width counter
`ifndef COIN_PULSE_WIDTH_COUNTER_UNIT_ASSERT_SVH
`define COIN_PULSE_WIDTH_COUNTER_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
`define CPWC_ASSERT_RST(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error(msg);
`define CPWC_ASSERT(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);
`else
`define CPWC_ASSERT_RST(label, clk, rst_n, prop, msg)
`define CPWC_ASSERT(label, clk, prop, msg)
`endif

`endif

/* hw/rtl/cpwc_pkg.sv */
`timescale 1ns / 1ps

package cpwc_pkg;

    localparam int CFG_BITS       = 16;
    localparam int CFG_IDX_BITS   = 2;
    localparam int TS_BITS        = 32;
    localparam int LINE_BITS      = 4;
    localparam int MODE_BITS      = 2;
    localparam int REPORT_BITS    = 2;
    localparam int OUT_COUNT_BITS = 16;
    localparam int METER_BITS     = 32;

    localparam logic [CFG_BITS-1:0] MIN_WIDTH_RST = 16'd10;
    localparam logic [CFG_BITS-1:0] MAX_WIDTH_RST = 16'd500;
    localparam logic [CFG_BITS-1:0] IDLE_TIME_RST = 16'd2000;

    localparam logic [MODE_BITS-1:0] MODE_NORMAL = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_ADMIN  = 2'd1;

    localparam logic [REPORT_BITS-1:0] REPORT_NONE   = 2'd0;
    localparam logic [REPORT_BITS-1:0] REPORT_NORMAL = 2'd1;
    localparam logic [REPORT_BITS-1:0] REPORT_ADMIN  = 2'd2;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        CFG_MIN_WIDTH = 2'd0,
        CFG_MAX_WIDTH = 2'd1,
        CFG_IDLE_TIME = 2'd2
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_BITS-1:0] width_lo;
        logic [CFG_BITS-1:0] width_hi;
        logic [CFG_BITS-1:0] idle_time;
    } t_cfg;

    typedef struct packed {
        logic [TS_BITS-1:0]   timestamp_ms;
        logic [LINE_BITS-1:0] line_levels;
        logic [MODE_BITS-1:0] op_mode;
    } t_scan;

    typedef struct packed {
        logic [LINE_BITS-1:0]      counted_mask;
        logic [REPORT_BITS-1:0]    report_set;
        logic [OUT_COUNT_BITS-1:0] count_ch0;
        logic [OUT_COUNT_BITS-1:0] count_ch1;
        logic [OUT_COUNT_BITS-1:0] count_ch2;
        logic [OUT_COUNT_BITS-1:0] count_ch3;
    } t_result;

endpackage

/* hw/rtl/cpwc_lane.sv */
`timescale 1ns / 1ps

module cpwc_lane import cpwc_pkg::*; #(
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_accept,
    input  logic [TIME_BITS-1:0]  i_now,
    input  logic                  i_level,
    input  logic [MODE_BITS-1:0]  i_mode,
    input  t_cfg                  i_cfg,
    output logic                  o_counted,
    output logic [COUNT_BITS-1:0] o_normal,
    output logic [COUNT_BITS-1:0] o_admin
);

    logic                  r_last_level;
    logic                  r_idle_level;
    logic [TIME_BITS-1:0]  r_last_change;
    logic [COUNT_BITS-1:0] r_normal;
    logic [COUNT_BITS-1:0] r_admin;
    logic [METER_BITS-1:0] r_meter;

    logic                  n_idle_level;
    logic [TIME_BITS-1:0]  n_last_change;
    logic [COUNT_BITS-1:0] n_normal;
    logic [COUNT_BITS-1:0] n_admin;
    logic [METER_BITS-1:0] n_meter;

    logic [TIME_BITS-1:0]  w_dt;
    logic                  w_changed;
    logic                  w_in_window;
    logic                  w_pulse;
    logic                  w_cnt_normal;
    logic                  w_cnt_admin;

    always_comb begin
        w_dt         = i_now - r_last_change;
        w_changed    = i_level != r_last_level;
        w_in_window  = (w_dt >= TIME_BITS'(i_cfg.width_lo))
                    && (w_dt <= TIME_BITS'(i_cfg.width_hi));
        w_pulse      = w_changed && (i_level == r_idle_level) && w_in_window;
        w_cnt_normal = w_pulse && (i_mode == MODE_NORMAL);
        w_cnt_admin  = w_pulse && (i_mode == MODE_ADMIN);

        n_normal      = w_cnt_normal ? r_normal + COUNT_BITS'(1) : r_normal;
        n_meter       = w_cnt_normal ? r_meter + METER_BITS'(1) : r_meter;
        n_admin       = w_cnt_admin ? r_admin + COUNT_BITS'(1) : r_admin;
        n_last_change = w_changed ? i_now : r_last_change;
        n_idle_level  = (!w_changed && (w_dt > TIME_BITS'(i_cfg.idle_time)))
                      ? i_level : r_idle_level;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_level  <= 1'b0;
            r_idle_level  <= 1'b0;
            r_last_change <= '0;
            r_normal      <= '0;
            r_admin       <= '0;
            r_meter       <= '0;
        end else if (i_accept) begin
            r_last_level  <= i_level;
            r_idle_level  <= n_idle_level;
            r_last_change <= n_last_change;
            r_normal      <= n_normal;
            r_admin       <= n_admin;
            r_meter       <= n_meter;
        end
    end

    assign o_counted = w_cnt_normal || w_cnt_admin;
    assign o_normal  = n_normal;
    assign o_admin   = n_admin;

endmodule

/* hw/rtl/cpwc_merge.sv */
`timescale 1ns / 1ps

module cpwc_merge import cpwc_pkg::*; #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_accept,
    input  logic [MODE_BITS-1:0]                 i_mode,
    input  logic [CHANNELS-1:0]                  i_counted,
    input  logic [CHANNELS-1:0][COUNT_BITS-1:0]  i_normal,
    input  logic [CHANNELS-1:0][COUNT_BITS-1:0]  i_admin,
    input  logic                                 i_out_stall,
    output logic                                 o_out_valid,
    output t_result                              o_out_data,
    output logic                                 o_in_stall
);

    logic [REPORT_BITS-1:0]                   w_report;
    logic [LINE_BITS-1:0]                     w_mask;
    logic [LINE_BITS-1:0][OUT_COUNT_BITS-1:0] w_counts;
    t_result                                  w_res;

    logic    r_out_valid;
    t_result r_out;
    logic    r_skid_valid;
    t_result r_skid;
    logic    w_load_out;

    always_comb begin
        if (i_counted == '0) begin
            w_report = REPORT_NONE;
        end else if (i_mode == MODE_NORMAL) begin
            w_report = REPORT_NORMAL;
        end else begin
            w_report = REPORT_ADMIN;
        end
    end

    for (genvar k = 0; k < LINE_BITS; k++) begin : g_out
        if (k < CHANNELS) begin : g_used
            assign w_mask[k]   = i_counted[k];
            assign w_counts[k] = (w_report == REPORT_NORMAL) ? OUT_COUNT_BITS'(i_normal[k])
                               : (w_report == REPORT_ADMIN)  ? OUT_COUNT_BITS'(i_admin[k])
                               : '0;
        end else begin : g_unused
            assign w_mask[k]   = 1'b0;
            assign w_counts[k] = '0;
        end
    end

    always_comb begin
        w_res.counted_mask = w_mask;
        w_res.report_set   = w_report;
        w_res.count_ch0    = w_counts[0];
        w_res.count_ch1    = w_counts[1];
        w_res.count_ch2    = w_counts[2];
        w_res.count_ch3    = w_counts[3];
    end

    // output register plus skid entry
    assign w_load_out = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (w_load_out) begin
            if (r_skid_valid) begin
                r_out_valid  <= 1'b1;
                r_skid_valid <= 1'b0;
            end else begin
                r_out_valid  <= i_accept;
            end
        end else if (i_accept) begin
            r_skid_valid <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out <= r_skid_valid ? r_skid : w_res;
        end else if (i_accept) begin
            r_skid <= w_res;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_in_stall  = r_skid_valid;

endmodule

/* hw/rtl/coin_pulse_width_counter_unit.sv */
// Coin pulse width counter.
// Input channel (i_in_valid / o_in_stall / i_in_data): one scan per request,
// carrying a millisecond timestamp, the coin line levels and the mode.
// Output channel (o_out_valid / i_out_stall / o_out_data): one result per
// scan with the counted mask, the reported set and four channel counts.
// Config port (i_cfg_we / i_cfg_idx / i_cfg_data): min width, max width and
// idle time; write only while no scan is in flight.
// Each channel has its own lane (level, idle level, change time, counters);
// all lanes update in the cycle a scan is accepted and a merge stage builds
// the result.
// The result of an accepted scan is registered in the output register, or in the skid entry when the output stalls.
// Throughput: one scan per cycle while the input is not stalled.
// Reset (synchronous, active low) clears all channel state and counters and
// loads the default widths and idle time.
// When the receiver stalls, one more scan lands in a skid entry; the input
// then stalls until the output drains.
`timescale 1ns / 1ps
`include "coin_pulse_width_counter_unit_assert.svh"

module coin_pulse_width_counter_unit import cpwc_pkg::*; #(
    parameter int CHANNELS   = 4,
    parameter int COUNT_BITS = 16,
    parameter int TIME_BITS  = 32
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_in_valid,
    output logic                    o_in_stall,
    input  t_scan                   i_in_data,
    output logic                    o_out_valid,
    input  logic                    i_out_stall,
    output t_result                 o_out_data,
    input  logic                    i_cfg_we,
    input  logic [CFG_IDX_BITS-1:0] i_cfg_idx,
    input  logic [CFG_BITS-1:0]     i_cfg_data
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    logic                                w_accept;
    logic [TIME_BITS-1:0]                w_now;
    logic [CHANNELS-1:0]                 w_level;
    logic [CHANNELS-1:0]                 w_counted;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] w_normal;
    logic [CHANNELS-1:0][COUNT_BITS-1:0] w_admin;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_WIDTH: n_cfg.width_lo  = i_cfg_data;
                CFG_MAX_WIDTH: n_cfg.width_hi  = i_cfg_data;
                CFG_IDLE_TIME: n_cfg.idle_time = i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.width_lo  <= MIN_WIDTH_RST;
            r_cfg.width_hi  <= MAX_WIDTH_RST;
            r_cfg.idle_time <= IDLE_TIME_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign w_accept = i_in_valid && !o_in_stall;
    assign w_now    = i_in_data.timestamp_ms[TIME_BITS-1:0];

    for (genvar c = 0; c < CHANNELS; c++) begin : g_lane
        if (c < LINE_BITS) begin : g_line
            assign w_level[c] = i_in_data.line_levels[c];
        end else begin : g_noline
            assign w_level[c] = 1'b0;
        end

        cpwc_lane #(
            .COUNT_BITS (COUNT_BITS),
            .TIME_BITS  (TIME_BITS)
        ) u_lane (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_accept  (w_accept),
            .i_now     (w_now),
            .i_level   (w_level[c]),
            .i_mode    (i_in_data.op_mode),
            .i_cfg     (r_cfg),
            .o_counted (w_counted[c]),
            .o_normal  (w_normal[c]),
            .o_admin   (w_admin[c])
        );
    end

    cpwc_merge #(
        .CHANNELS   (CHANNELS),
        .COUNT_BITS (COUNT_BITS)
    ) u_merge (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_mode      (i_in_data.op_mode),
        .i_counted   (w_counted),
        .i_normal    (w_normal),
        .i_admin     (w_admin),
        .i_out_stall (i_out_stall),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .o_in_stall  (o_in_stall)
    );

    `CPWC_ASSERT_RST(a_stall_has_out, i_clk, i_rst_n,
        o_in_stall |-> o_out_valid, "input stalled with empty output")
    `CPWC_ASSERT_RST(a_mask_reports, i_clk, i_rst_n,
        (o_out_valid && (o_out_data.counted_mask != '0))
            |-> (o_out_data.report_set != REPORT_NONE),
        "counted coin without report set")
    `CPWC_ASSERT_RST(a_cfg_min_write, i_clk, i_rst_n,
        (i_cfg_we && (i_cfg_idx == CFG_MIN_WIDTH))
            |=> (r_cfg.width_lo == $past(i_cfg_data)),
        "min width write lost")

endmodule

/* sim/tb_coin_pulse_width_counter_unit.sv */
`timescale 1ns / 1ps

module tb_coin_pulse_width_counter_unit;
    import cpwc_pkg::*;

    localparam int NUM_CH = LINE_BITS;
    localparam logic [MODE_BITS-1:0] MODE_OFF = 2'd2;
    localparam logic [MODE_BITS-1:0] MODE_SPARE = 2'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_IDX_SPARE = 2'd3;
    localparam bit TYPED = 1'b1;
    localparam bit FREE = 1'b0;
    localparam int PULSE_MS = 50;
    localparam int TRAIN_PULSES = 10;
    localparam int HOLD_CYCLES = 80;

    typedef struct {
        t_scan   scan;
        bit      typed;
        t_result res;
    } t_dir_row;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    t_scan in_data = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    t_result out_data;
    logic cfg_we = 1'b0;
    logic [CFG_IDX_BITS-1:0] cfg_idx = '0;
    logic [CFG_BITS-1:0] cfg_data = '0;

    // typed expectation travels alongside the request it belongs to
    bit typed_valid = 1'b0;
    t_result typed_result = '0;

    int send_idle_pct = 0;
    int stall_pct = 0;
    bit hold_request = 1'b0;
    bit hold_taken = 1'b0;
    int hold_left = 0;
    int fail_count = 0;

    t_result pending_results[$];
    t_dir_row dir_rows[$];

    logic [TS_BITS-1:0] stim_time = '0;
    logic [LINE_BITS-1:0] stim_levels = '0;

    // coin counter state as the block should hold it
    logic [CFG_BITS-1:0] min_w = MIN_WIDTH_RST;
    logic [CFG_BITS-1:0] max_w = MAX_WIDTH_RST;
    logic [CFG_BITS-1:0] idle_w = IDLE_TIME_RST;
    logic line_level [NUM_CH] = '{default: 1'b0};
    logic rest_level [NUM_CH] = '{default: 1'b0};
    logic [TS_BITS-1:0] edge_time [NUM_CH] = '{default: '0};
    logic [OUT_COUNT_BITS-1:0] normal_coins [NUM_CH] = '{default: '0};
    logic [OUT_COUNT_BITS-1:0] admin_coins [NUM_CH] = '{default: '0};
    logic [METER_BITS-1:0] meter_coins [NUM_CH] = '{default: '0};

    coin_pulse_width_counter_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_we    (cfg_we),
        .i_cfg_idx   (cfg_idx),
        .i_cfg_data  (cfg_data)
    );

    initial begin : clock_gen
        forever #2 clk = ~clk;
    end

    initial begin : watchdog
        #20_000_000;
        $display("FAIL coin_pulse_width_counter_unit");
        $finish;
    end

    function automatic t_result coin_result(input t_scan s);
        t_result r;
        logic [TS_BITS-1:0] dt;
        logic [OUT_COUNT_BITS-1:0] shown [NUM_CH];
        r = '0;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            dt = s.timestamp_ms - edge_time[ch];
            if (s.line_levels[ch] != line_level[ch]) begin
                if (s.line_levels[ch] == rest_level[ch] && dt >= min_w && dt <= max_w) begin
                    if (s.op_mode == MODE_NORMAL) begin
                        normal_coins[ch] = normal_coins[ch] + 1'b1;
                        meter_coins[ch] = meter_coins[ch] + 1'b1;
                        r.counted_mask[ch] = 1'b1;
                        r.report_set = REPORT_NORMAL;
                    end else if (s.op_mode == MODE_ADMIN) begin
                        admin_coins[ch] = admin_coins[ch] + 1'b1;
                        r.counted_mask[ch] = 1'b1;
                        r.report_set = REPORT_ADMIN;
                    end
                end
                line_level[ch] = s.line_levels[ch];
                edge_time[ch] = s.timestamp_ms;
            end else if (dt > idle_w) begin
                rest_level[ch] = s.line_levels[ch];
            end
        end
        for (int ch = 0; ch < NUM_CH; ch++) begin
            if (r.report_set == REPORT_NORMAL) begin
                shown[ch] = normal_coins[ch];
            end else if (r.report_set == REPORT_ADMIN) begin
                shown[ch] = admin_coins[ch];
            end else begin
                shown[ch] = '0;
            end
        end
        r.count_ch0 = shown[0];
        r.count_ch1 = shown[1];
        r.count_ch2 = shown[2];
        r.count_ch3 = shown[3];
        return r;
    endfunction

    always @(posedge clk) begin : scoreboard
        t_result want;
        t_result got;
        if (rst_n) begin
            if (in_valid && !in_stall) begin
                want = coin_result(in_data);
                pending_results.push_back(typed_valid ? typed_result : want);
            end
            if (out_valid && !out_stall) begin
                got = out_data;
                if (pending_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10) begin
                        $display("unexpected result: mask %h set %0d counts %h %h %h %h",
                                 got.counted_mask, got.report_set, got.count_ch0,
                                 got.count_ch1, got.count_ch2, got.count_ch3);
                    end
                end else begin
                    want = pending_results.pop_front();
                    if (got.counted_mask !== want.counted_mask ||
                        got.report_set !== want.report_set ||
                        got.count_ch0 !== want.count_ch0 || got.count_ch1 !== want.count_ch1 ||
                        got.count_ch2 !== want.count_ch2 || got.count_ch3 !== want.count_ch3) begin
                        fail_count++;
                        if (fail_count <= 10) begin
                            $display("mismatch: mask %h/%h set %0d/%0d (exp/got)",
                                     want.counted_mask, got.counted_mask,
                                     want.report_set, got.report_set);
                            $display("  counts exp %h %h %h %h got %h %h %h %h",
                                     want.count_ch0, want.count_ch1, want.count_ch2,
                                     want.count_ch3, got.count_ch0, got.count_ch1,
                                     got.count_ch2, got.count_ch3);
                        end
                    end
                end
            end
        end
    end

    // receiver: random stall, plus one long hold-off on request
    always @(posedge clk) begin
        if (hold_request && !hold_taken) begin
            hold_taken <= 1'b1;
            hold_left <= HOLD_CYCLES;
            out_stall <= 1'b1;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_scan(input t_scan s, input bit typed, input t_result r);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data <= s;
        typed_valid <= typed;
        typed_result <= r;
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_results.size() != 0) @(posedge clk);
        repeat (2) @(posedge clk);
    endtask

    task automatic reg_write(input logic [CFG_IDX_BITS-1:0] idx,
                             input logic [CFG_BITS-1:0] value);
        cfg_we <= 1'b1;
        cfg_idx <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            CFG_MIN_WIDTH: min_w = value;
            CFG_MAX_WIDTH: max_w = value;
            CFG_IDLE_TIME: idle_w = value;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [CFG_BITS-1:0] min_v, max_v, idle_v);
        reg_write(CFG_MIN_WIDTH, min_v);
        reg_write(CFG_MAX_WIDTH, max_v);
        reg_write(CFG_IDLE_TIME, idle_v);
        reg_write(CFG_IDX_SPARE, CFG_BITS'($urandom));
        cfg_we <= 1'b0;
    endtask

    task automatic add_row(input logic [TS_BITS-1:0] ts, input logic [LINE_BITS-1:0] lv,
                           input logic [MODE_BITS-1:0] md, input bit typed,
                           input logic [LINE_BITS-1:0] mask,
                           input logic [REPORT_BITS-1:0] rset,
                           input logic [OUT_COUNT_BITS-1:0] c0, c1, c2, c3);
        t_dir_row row;
        row.scan.timestamp_ms = ts;
        row.scan.line_levels = lv;
        row.scan.op_mode = md;
        row.typed = typed;
        row.res.counted_mask = mask;
        row.res.report_set = rset;
        row.res.count_ch0 = c0;
        row.res.count_ch1 = c1;
        row.res.count_ch2 = c2;
        row.res.count_ch3 = c3;
        dir_rows.push_back(row);
    endtask

    // alternate every line each scan so each channel returns to idle every other request
    task automatic pulse_train(input logic [MODE_BITS-1:0] mode, input int pulses);
        t_scan s;
        for (int n = 0; n < 2 * pulses; n++) begin
            stim_time += PULSE_MS;
            stim_levels = ~stim_levels;
            s.timestamp_ms = stim_time;
            s.line_levels = stim_levels;
            s.op_mode = mode;
            send_scan(s, FREE, '0);
        end
    endtask

    task automatic send_random_scan();
        t_scan s;
        logic [TS_BITS-1:0] step;
        bit hold_levels;
        hold_levels = 1'b0;
        case ($urandom_range(9))
            0: step = $urandom_range(3);
            1, 2, 3, 4: step = $urandom_range(max_w + 8);
            5: step = min_w + $urandom_range(2) - 1;
            6: step = max_w + $urandom_range(2) - 1;
            7: begin
                step = idle_w + $urandom_range(2);
                hold_levels = 1'b1;
            end
            8: step = $urandom_range(min_w);
            default: step = $urandom;
        endcase
        stim_time += step;
        if (!hold_levels && $urandom_range(9) < 6) begin
            stim_levels ^= LINE_BITS'($urandom_range(1, 15));
        end
        case ($urandom_range(9))
            0: s.op_mode = MODE_OFF;
            1: s.op_mode = MODE_SPARE;
            2, 3, 4: s.op_mode = MODE_ADMIN;
            default: s.op_mode = MODE_NORMAL;
        endcase
        s.timestamp_ms = stim_time;
        s.line_levels = stim_levels;
        send_scan(s, FREE, '0);
    endtask

    task automatic random_phase(input int items, input int idle_pct, input int stall_p);
        send_idle_pct = idle_pct;
        stall_pct = stall_p;
        repeat (items) send_random_scan();
    endtask

    initial begin : stimulus
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // default widths: 10..500 ms, idle after 2000 ms
        add_row(32'd5, 4'h0, MODE_NORMAL, TYPED, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd100, 4'hF, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd150, 4'h0, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd200, 4'h1, MODE_ADMIN, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd210, 4'h0, MODE_ADMIN, TYPED, 4'h1, REPORT_ADMIN, 1, 0, 0, 0);
        add_row(32'd300, 4'h2, MODE_OFF, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd400, 4'h0, MODE_OFF, TYPED, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd500, 4'h4, MODE_SPARE, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd600, 4'h0, MODE_SPARE, TYPED, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd1000, 4'h8, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd1500, 4'h0, MODE_NORMAL, TYPED, 4'h8, REPORT_NORMAL, 1, 1, 1, 2);
        add_row(32'd2000, 4'h1, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd2009, 4'h0, MODE_NORMAL, TYPED, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd3000, 4'h2, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd3501, 4'h0, MODE_NORMAL, TYPED, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        // learn idle high, then pulse low and back
        add_row(32'd3600, 4'hF, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd5601, 4'hF, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd5700, 4'h0, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd5800, 4'hF, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        // pulse across the timestamp wrap
        add_row(32'hFFFF_FFFF, 4'h0, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'h0000_0020, 4'hF, MODE_NORMAL, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd100, 4'h9, MODE_ADMIN, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        add_row(32'd150, 4'hF, MODE_ADMIN, FREE, 4'h0, REPORT_NONE, 0, 0, 0, 0);
        foreach (dir_rows[k]) send_scan(dir_rows[k].scan, dir_rows[k].typed, dir_rows[k].res);
        wait_drained();

        stim_time = 32'd200;
        stim_levels = 4'hF;
        load_config(MIN_WIDTH_RST, MAX_WIDTH_RST, IDLE_TIME_RST);
        pulse_train(MODE_NORMAL, TRAIN_PULSES);
        pulse_train(MODE_ADMIN, TRAIN_PULSES);
        random_phase(150, 0, 0);
        wait_drained();

        load_config(16'd0, 16'hFFFF, 16'd0);
        random_phase(150, 81, 0);
        wait_drained();

        load_config(16'hFFFF, 16'hFFFF, 16'hFFFF);
        random_phase(150, 0, 81);
        wait_drained();

        // min above max: nothing can count
        load_config(16'd300, 16'd100, 16'd500);
        random_phase(75, 15, 15);
        wait_drained();
        random_phase(75, 15, 15);
        wait_drained();

        load_config(16'd5, 16'd40, 16'd60);
        hold_request <= 1'b1;
        random_phase(150, 0, 15);
        wait_drained();

        load_config(MIN_WIDTH_RST, MAX_WIDTH_RST, IDLE_TIME_RST);
        random_phase(150, 0, 0);
        wait_drained();

        repeat (8) @(posedge clk);
        if (fail_count == 0) begin
            $display("PASS coin_pulse_width_counter_unit");
        end else begin
            $display("FAIL coin_pulse_width_counter_unit");
        end
        $finish;
    end

endmodule
